// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and helpers for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MaxPages    = 32768;
  localparam int MapWordBits = 32;
  localparam int PageShift   = 12;

  localparam int MapWords = MaxPages / MapWordBits;
  localparam int SumWords = MapWords / MapWordBits;

  localparam int BitIdxW  = $clog2(MapWordBits);
  localparam int WordIdxW = $clog2(MapWords);
  localparam int SumIdxW  = $clog2(SumWords);
  localparam int PageW    = $clog2(MaxPages);
  localparam int CountW   = 16;
  localparam int FreeAddrW = 32;
  localparam int FreePageW = FreeAddrW - PageShift;
  localparam int PageAddrW = PageW + PageShift;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  localparam logic [CountW-1:0] TotalReset    = 16'd32768;
  localparam logic [CountW-1:0] ReservedReset = 16'd1280;

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef logic [MapWordBits-1:0] map_word_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_ALLOC_SUM,
    S_ALLOC_MAP,
    S_FREE_MAP
  } state_t;

  typedef struct packed {
    logic [CountW-1:0] page_total;
    logic [CountW-1:0] reserved_pages;
  } cfg_t;

  // lowest clear bit of a word
  function automatic logic [BitIdxW-1:0] first_zero(input map_word_t w);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = MapWordBits - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = i[BitIdxW-1:0];
      end
    end
    return idx;
  endfunction

endpackage

// ----- hdl/bpa_regs.sv -----
// ----------------------------------------------------------------------------
// bpa_regs
// APB register file holding the page total and reserved page count.
// ----------------------------------------------------------------------------
module bpa_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpa_pkg::CfgAddrW-1:0]   paddr,
  input  logic [bpa_pkg::CfgDataW-1:0]   pwdata,
  output logic [bpa_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output bpa_pkg::cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_total     <= bpa_pkg::TotalReset;
      cfg.reserved_pages <= bpa_pkg::ReservedReset;
    end else if (wr_en) begin
      case (paddr[2])
        bpa_pkg::REG_TOTAL:    cfg.page_total     <= pwdata[bpa_pkg::CountW-1:0];
        bpa_pkg::REG_RESERVED: cfg.reserved_pages <= pwdata[bpa_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bpa_pkg::REG_TOTAL:
        prdata = {{(bpa_pkg::CfgDataW-bpa_pkg::CountW){1'b0}}, cfg.page_total};
      bpa_pkg::REG_RESERVED:
        prdata = {{(bpa_pkg::CfgDataW-bpa_pkg::CountW){1'b0}}, cfg.reserved_pages};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- hdl/bpa_init_gen.sv -----
// ----------------------------------------------------------------------------
// bpa_init_gen
// Initial contents of one map word: reserved pages and pages beyond the
// total are set.
// ----------------------------------------------------------------------------
module bpa_init_gen (
  input  logic [bpa_pkg::WordIdxW-1:0] word_idx,
  input  logic [bpa_pkg::CountW-1:0]   res_pages,
  input  logic [bpa_pkg::CountW-1:0]   total,
  output bpa_pkg::map_word_t           pattern
);

  localparam int HiW = bpa_pkg::CountW - bpa_pkg::BitIdxW;

  logic [HiW-1:0]             w;
  logic [HiW-1:0]             res_w;
  logic [HiW-1:0]             tot_w;
  bpa_pkg::map_word_t         low_mask;
  bpa_pkg::map_word_t         high_mask;
  bpa_pkg::map_word_t         res_part;
  bpa_pkg::map_word_t         tot_part;

  assign w        = HiW'(word_idx);
  assign res_w    = res_pages[bpa_pkg::CountW-1:bpa_pkg::BitIdxW];
  assign tot_w    = total[bpa_pkg::CountW-1:bpa_pkg::BitIdxW];
  assign res_part = (bpa_pkg::map_word_t'(1) << res_pages[bpa_pkg::BitIdxW-1:0])
                    - bpa_pkg::map_word_t'(1);
  assign tot_part = ~((bpa_pkg::map_word_t'(1) << total[bpa_pkg::BitIdxW-1:0])
                    - bpa_pkg::map_word_t'(1));

  always_comb begin
    if (w < res_w) begin
      low_mask = '1;
    end else if (w == res_w) begin
      low_mask = res_part;
    end else begin
      low_mask = '0;
    end
    if (w > tot_w) begin
      high_mask = '1;
    end else if (w == tot_w) begin
      high_mask = tot_part;
    end else begin
      high_mask = '0;
    end
  end

  assign pattern = low_mask | high_mask;

endmodule

// ----- hdl/bpa_engine.sv -----
// ----------------------------------------------------------------------------
// bpa_engine
// Request sequencer with the used-page map, the per-word full summary and
// the top-level summary register.
// ----------------------------------------------------------------------------
module bpa_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      op,
  input  logic [bpa_pkg::FreeAddrW-1:0]   free_address,
  input  bpa_pkg::cfg_t                   cfg,
  output logic                            busy,
  output logic                            done,
  output logic [bpa_pkg::PageAddrW-1:0]   page_address,
  output logic [1:0]                      status,
  output logic [bpa_pkg::CountW-1:0]      free_pages
);

  localparam int WIdx = bpa_pkg::WordIdxW;
  localparam int SIdx = bpa_pkg::SumIdxW;
  localparam int BIdx = bpa_pkg::BitIdxW;
  localparam int CW   = bpa_pkg::CountW;

  bpa_pkg::map_word_t map_mem [bpa_pkg::MapWords];
  bpa_pkg::map_word_t sum_mem [bpa_pkg::SumWords];

  bpa_pkg::state_t            state, state_next;
  logic [CW-1:0]              active_total, active_total_next;
  logic [CW-1:0]              res_pages, res_pages_next;
  logic [CW-1:0]              used_count, used_count_next;
  logic [bpa_pkg::SumWords-1:0] top, top_next;
  logic [WIdx-1:0]            sweep_idx, sweep_idx_next;
  bpa_pkg::map_word_t         sweep_acc, sweep_acc_next;
  logic                       init_report, init_report_next;
  logic [bpa_pkg::PageW-1:0]  page_r, page_r_next;
  logic [SIdx-1:0]            k_r, k_r_next;
  logic [BIdx-1:0]            j_r, j_r_next;
  bpa_pkg::map_word_t         sum_word, sum_word_next;

  logic [WIdx-1:0]            map_raddr, map_waddr;
  logic                       map_we;
  bpa_pkg::map_word_t         map_wdata, map_rdata;
  logic [SIdx-1:0]            sum_raddr, sum_waddr;
  logic                       sum_we;
  bpa_pkg::map_word_t         sum_wdata, sum_rdata;

  logic                       out_valid;
  logic [bpa_pkg::PageAddrW-1:0] out_addr;
  bpa_pkg::status_t           out_status;

  logic [bpa_pkg::FreePageW-1:0] req_page;
  logic [CW-1:0]              clamp_total, clamp_res;
  bpa_pkg::map_word_t         init_pattern;
  bpa_pkg::map_word_t         new_word, new_sum;
  logic [BIdx-1:0]            b_idx;

  assign req_page    = free_address[bpa_pkg::FreeAddrW-1:bpa_pkg::PageShift];
  assign clamp_total = (cfg.page_total > CW'(bpa_pkg::MaxPages)) ?
                       CW'(bpa_pkg::MaxPages) : cfg.page_total;
  assign clamp_res   = (cfg.reserved_pages < clamp_total) ?
                       cfg.reserved_pages : clamp_total;
  assign busy        = (state != bpa_pkg::S_IDLE);

  bpa_init_gen u_init_gen (
    .word_idx  (sweep_idx),
    .res_pages (res_pages),
    .total     (active_total),
    .pattern   (init_pattern)
  );

  always_ff @(posedge clk) begin
    map_rdata <= map_mem[map_raddr];
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    sum_rdata <= sum_mem[sum_raddr];
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bpa_pkg::S_SWEEP;
      active_total <= bpa_pkg::TotalReset;
      res_pages    <= bpa_pkg::ReservedReset;
      used_count   <= bpa_pkg::ReservedReset;
      top          <= '0;
      sweep_idx    <= '0;
      init_report  <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      active_total <= active_total_next;
      res_pages    <= res_pages_next;
      used_count   <= used_count_next;
      top          <= top_next;
      sweep_idx    <= sweep_idx_next;
      init_report  <= init_report_next;
      done         <= out_valid;
    end
  end

  always_ff @(posedge clk) begin
    sweep_acc <= sweep_acc_next;
    page_r    <= page_r_next;
    k_r       <= k_r_next;
    j_r       <= j_r_next;
    sum_word  <= sum_word_next;
    if (out_valid) begin
      page_address <= out_addr;
      status       <= out_status;
      free_pages   <= active_total_next - used_count_next;
    end
  end

  always_comb begin
    state_next        = state;
    active_total_next = active_total;
    res_pages_next    = res_pages;
    used_count_next   = used_count;
    top_next          = top;
    sweep_idx_next    = sweep_idx;
    sweep_acc_next    = sweep_acc;
    init_report_next  = init_report;
    page_r_next       = page_r;
    k_r_next          = k_r;
    j_r_next          = j_r;
    sum_word_next     = sum_word;
    map_raddr         = '0;
    map_waddr         = '0;
    map_we            = 1'b0;
    map_wdata         = '0;
    sum_raddr         = '0;
    sum_waddr         = '0;
    sum_we            = 1'b0;
    sum_wdata         = '0;
    out_valid         = 1'b0;
    out_addr          = '0;
    out_status        = bpa_pkg::ST_OK;
    new_word          = '0;
    new_sum           = '0;
    b_idx             = '0;

    case (state)
      bpa_pkg::S_IDLE: begin
        if (start) begin
          case (bpa_pkg::op_t'(op))
            bpa_pkg::OP_ALLOC: begin
              if (&top) begin
                out_valid  = 1'b1;
                out_status = bpa_pkg::ST_NO_FREE;
              end else begin
                k_r_next   = bpa_pkg::first_zero(top);
                sum_raddr  = k_r_next;
                state_next = bpa_pkg::S_ALLOC_SUM;
              end
            end
            bpa_pkg::OP_FREE: begin
              if (req_page >= bpa_pkg::FreePageW'(active_total)) begin
                out_valid  = 1'b1;
                out_status = bpa_pkg::ST_OUT_OF_RANGE;
              end else begin
                page_r_next = req_page[bpa_pkg::PageW-1:0];
                map_raddr   = req_page[bpa_pkg::PageW-1:BIdx];
                sum_raddr   = req_page[bpa_pkg::PageW-1:bpa_pkg::PageW-SIdx];
                state_next  = bpa_pkg::S_FREE_MAP;
              end
            end
            bpa_pkg::OP_INIT: begin
              active_total_next = clamp_total;
              res_pages_next    = clamp_res;
              used_count_next   = clamp_res;
              sweep_idx_next    = '0;
              init_report_next  = 1'b1;
              state_next        = bpa_pkg::S_SWEEP;
            end
            default: begin
              out_valid = 1'b1;
            end
          endcase
        end
      end

      bpa_pkg::S_SWEEP: begin
        map_we         = 1'b1;
        map_waddr      = sweep_idx;
        map_wdata      = init_pattern;
        sweep_acc_next = {&init_pattern, sweep_acc[bpa_pkg::MapWordBits-1:1]};
        if (&sweep_idx[BIdx-1:0]) begin
          sum_we    = 1'b1;
          sum_waddr = sweep_idx[WIdx-1:BIdx];
          sum_wdata = sweep_acc_next;
          top_next[sweep_idx[WIdx-1:BIdx]] = &sweep_acc_next;
        end
        if (sweep_idx == WIdx'(bpa_pkg::MapWords - 1)) begin
          state_next       = bpa_pkg::S_IDLE;
          init_report_next = 1'b0;
          out_valid        = init_report;
        end else begin
          sweep_idx_next = sweep_idx + WIdx'(1);
        end
      end

      bpa_pkg::S_ALLOC_SUM: begin
        j_r_next      = bpa_pkg::first_zero(sum_rdata);
        sum_word_next = sum_rdata;
        map_raddr     = {k_r, j_r_next};
        state_next    = bpa_pkg::S_ALLOC_MAP;
      end

      bpa_pkg::S_ALLOC_MAP: begin
        b_idx     = bpa_pkg::first_zero(map_rdata);
        new_word  = map_rdata | (bpa_pkg::map_word_t'(1) << b_idx);
        new_sum   = sum_word | (bpa_pkg::map_word_t'(1) << j_r);
        map_we    = 1'b1;
        map_waddr = {k_r, j_r};
        map_wdata = new_word;
        if (&new_word) begin
          sum_we    = 1'b1;
          sum_waddr = k_r;
          sum_wdata = new_sum;
          if (&new_sum) begin
            top_next[k_r] = 1'b1;
          end
        end
        used_count_next = used_count + CW'(1);
        out_valid       = 1'b1;
        out_addr        = {k_r, j_r, b_idx, {bpa_pkg::PageShift{1'b0}}};
        state_next      = bpa_pkg::S_IDLE;
      end

      bpa_pkg::S_FREE_MAP: begin
        out_valid  = 1'b1;
        state_next = bpa_pkg::S_IDLE;
        if (map_rdata[page_r[BIdx-1:0]]) begin
          map_we    = 1'b1;
          map_waddr = page_r[bpa_pkg::PageW-1:BIdx];
          map_wdata = map_rdata & ~(bpa_pkg::map_word_t'(1) << page_r[BIdx-1:0]);
          sum_we    = 1'b1;
          sum_waddr = page_r[bpa_pkg::PageW-1:bpa_pkg::PageW-SIdx];
          sum_wdata = sum_rdata &
                      ~(bpa_pkg::map_word_t'(1) << page_r[WIdx-1:BIdx]);
          top_next[page_r[bpa_pkg::PageW-1:bpa_pkg::PageW-SIdx]] = 1'b0;
          if (used_count != '0) begin
            used_count_next = used_count - CW'(1);
          end
        end else begin
          out_status = bpa_pkg::ST_ALREADY_FREE;
        end
      end

      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/bitmap_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit physical page allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// Requests: a beat is taken when start is high and busy is low. op selects
// allocate, free (page from free_address[31:12]) or reinitialise.
// Results: one per request, on page_address/status/free_pages for a single
// cycle with done high. The receiver cannot stall; results are never held.
// Steps from the accepting edge to done:
//   allocate with a free page  summary read, map read, write back
//   free inside the total      map read, write back
//   out of range, map full, unused op  answered from the idle state
//   reinitialise               whole map rewritten, one map word written per cycle
// busy is low again in the cycle done shows, so the next beat may follow.
// The map search is bounded by the two-level summary, not the page count.
// Reset: registers take their reset values and an initialisation pass
// writes the map and summary; busy stays high throughout, no result given.
// APB: page total at 0x0, reserved_pages at 0x4; they apply at next init.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      op,
  input  logic [bpa_pkg::FreeAddrW-1:0]   free_address,
  output logic                            busy,
  output logic                            done,
  output logic [bpa_pkg::PageAddrW-1:0]   page_address,
  output logic [1:0]                      status,
  output logic [bpa_pkg::CountW-1:0]      free_pages,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpa_pkg::CfgAddrW-1:0]    paddr,
  input  logic [bpa_pkg::CfgDataW-1:0]    pwdata,
  output logic [bpa_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready
);

  bpa_pkg::cfg_t cfg;

  bpa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpa_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .free_address (free_address),
    .cfg          (cfg),
    .busy         (busy),
    .done         (done),
    .page_address (page_address),
    .status       (status),
    .free_pages   (free_pages)
  );

endmodule

// ----- hdl/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic [1:0]                      op,
  input logic                            busy,
  input logic                            done,
  input logic [bpa_pkg::PageAddrW-1:0]   page_address,
  input logic [1:0]                      status,
  input logic [bpa_pkg::CountW-1:0]      free_pages
);

  a_unused_op_immediate: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == bpa_pkg::OP_NONE) |=>
      (done && status == bpa_pkg::ST_OK && page_address == '0))
    else $error("unused op did not return an immediate ok beat");

  a_fail_no_address: assert property (@(posedge clk) disable iff (rst)
    (done && status != bpa_pkg::ST_OK) |-> (page_address == '0))
    else $error("failed request returned a page address");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (free_pages <= bpa_pkg::CountW'(bpa_pkg::MaxPages)))
    else $error("free page count beyond map size");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .op           (op),
  .busy         (busy),
  .done         (done),
  .page_address (page_address),
  .status       (status),
  .free_pages   (free_pages)
);
